FILE: src/urae_pkg.sv
package urae_pkg;

    // input item function codes (carried in s_tuser)
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_RX    = 2'd2;
    localparam logic [1:0] FUNC_TICK  = 2'd3;

    // result item kinds (carried in m_tuser)
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // completion status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FAILED = 2'd1;
    localparam logic [1:0] ST_BADLEN = 2'd2;
    localparam logic [1:0] ST_BUSY   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_ATTEMPTS = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT      = 2'd1;
    localparam logic [1:0] CFG_BACKOFF      = 2'd2;

    // configuration reset values
    localparam logic [3:0] RST_MAX_ATTEMPTS = 4'd5;
    localparam logic [7:0] RST_TIMEOUT      = 8'd30;
    localparam logic [7:0] RST_BACKOFF      = 8'd3;

    // protocol bytes
    localparam logic [7:0] BYTE_SYNC     = 8'hAA;
    localparam logic [7:0] BYTE_OP_WRITE = 8'h00;
    localparam logic [7:0] BYTE_OP_READ  = 8'h01;
    localparam logic [7:0] BYTE_WR_LEN   = 8'h01;
    localparam logic [7:0] BYTE_WR_ACK0  = 8'hEE;
    localparam logic [7:0] BYTE_WR_ACK1  = 8'h01;
    localparam logic [7:0] BYTE_RD_HDR   = 8'hBB;

    // index of the final byte of a command frame
    localparam logic [2:0] RD_LAST_IDX = 3'd3;
    localparam logic [2:0] WR_LAST_IDX = 3'd4;

    localparam logic [3:0] ATTEMPT_SAT = 4'd15;
    localparam logic [7:0] TICK_SAT    = 8'd255;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       load_req;      // capture a start request
        logic       load_rd;       // the start request is a read
        logic       begin_cmd;     // a command frame starts: count attempt, clear timers
        logic       save_hdr;      // capture the first header byte
        logic       tick_inc;      // count one tick
        logic       tick_clr;      // clear the tick counter
        logic       pay_start;     // payload phase starts
        logic       pay_write;     // store one payload byte
        logic       rd_start;      // rewind the payload read pointer
        logic       rd_issue;      // read one payload byte
        logic       emit_cmd_byte; // load a command byte into the output
        logic       emit_status;   // load a completion status into the output
        logic       emit_data;     // load a read data byte into the output
        logic [2:0] byte_idx;      // command byte position
        logic [1:0] status_code;   // status to report
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_read;
        logic out_free;
        logic bad_len;
        logic hdr_ok;
        logic attempts_done;
        logic timeout_hit;
        logic backoff_hit;
        logic backoff_zero;
        logic payload_done;
        logic rd_last;
    } sts_t;

endpackage

FILE: src/urae_dp.sv
module urae_dp #(
    parameter int MAX_READ_LEN = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  urae_pkg::cmd_t     cmd,
    output urae_pkg::sts_t     sts,
    input  logic [7:0]         reg_addr,
    input  logic [7:0]         read_len,
    input  logic [7:0]         write_data,
    input  logic [7:0]         rx_byte,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [1:0]         out_kind,
    output logic [7:0]         out_value,
    output logic [1:0]         out_status,
    output logic               out_last
);

    localparam int AW = (MAX_READ_LEN > 1) ? $clog2(MAX_READ_LEN) : 1;
    localparam int LW = $clog2(MAX_READ_LEN + 1);
    localparam int CW = LW + 1;

    logic [3:0]    max_att_reg;
    logic [7:0]    timeout_reg;
    logic [7:0]    backoff_reg;
    logic          is_read_reg;
    logic [3:0]    attempt_reg;
    logic [7:0]    tick_reg;
    logic [LW-1:0] bytes_reg;
    logic [LW-1:0] rd_ptr_reg;
    logic [7:0]    hdr_reg;
    logic [7:0]    sreg_reg;
    logic [LW-1:0] slen_reg;
    logic [7:0]    sdata_reg;
    logic [7:0]    mem [MAX_READ_LEN];
    logic [7:0]    mem_q_reg;
    logic          out_valid_reg;
    logic [1:0]    out_kind_reg;
    logic [7:0]    out_value_reg;
    logic [1:0]    out_status_reg;
    logic          out_last_reg;

    logic [7:0]    tick_next;
    logic [CW-1:0] bytes_inc;
    logic [LW-1:0] rd_ptr_inc;
    logic [7:0]    cmd_byte;
    logic          out_load;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_att_reg <= urae_pkg::RST_MAX_ATTEMPTS;
            timeout_reg <= urae_pkg::RST_TIMEOUT;
            backoff_reg <= urae_pkg::RST_BACKOFF;
        end else if (cfg_valid) begin
            case (cfg_index)
                urae_pkg::CFG_MAX_ATTEMPTS: max_att_reg <= cfg_data[3:0];
                urae_pkg::CFG_TIMEOUT:      timeout_reg <= cfg_data;
                urae_pkg::CFG_BACKOFF:      backoff_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturating tick increment and plain counter increments
    assign tick_next  = (tick_reg == urae_pkg::TICK_SAT) ? tick_reg : tick_reg + 8'd1;
    assign bytes_inc  = CW'(bytes_reg) + CW'(1);
    assign rd_ptr_inc = rd_ptr_reg + LW'(1);

    // run control counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            is_read_reg <= 1'b0;
            attempt_reg <= '0;
            tick_reg    <= '0;
            bytes_reg   <= '0;
            rd_ptr_reg  <= '0;
        end else begin
            if (cmd.load_req) begin
                is_read_reg <= cmd.load_rd;
            end
            if (cmd.begin_cmd) begin
                if (cmd.load_req) begin
                    attempt_reg <= 4'd1;
                end else if (attempt_reg != urae_pkg::ATTEMPT_SAT) begin
                    attempt_reg <= attempt_reg + 4'd1;
                end
            end
            if (cmd.begin_cmd || cmd.tick_clr || cmd.pay_start) begin
                tick_reg <= '0;
            end else if (cmd.tick_inc) begin
                tick_reg <= tick_next;
            end
            if (cmd.begin_cmd || cmd.pay_start) begin
                bytes_reg <= '0;
            end else if (cmd.pay_write) begin
                bytes_reg <= bytes_inc[LW-1:0];
            end
            if (cmd.rd_start) begin
                rd_ptr_reg <= '0;
            end else if (cmd.rd_issue) begin
                rd_ptr_reg <= rd_ptr_inc;
            end
        end
    end

    // request fields and header capture
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            sreg_reg  <= reg_addr;
            sdata_reg <= cmd.load_rd ? 8'd0 : write_data;
            slen_reg  <= cmd.load_rd ? read_len[LW-1:0] : '0;
        end
        if (cmd.save_hdr) begin
            hdr_reg <= rx_byte;
        end
    end

    // payload store, registered read
    always_ff @(posedge aclk) begin
        if (cmd.pay_write) begin
            mem[bytes_reg[AW-1:0]] <= rx_byte;
        end
        if (cmd.rd_issue) begin
            mem_q_reg <= mem[rd_ptr_reg[AW-1:0]];
        end
    end

    // command frame byte select
    always_comb begin
        case (cmd.byte_idx)
            3'd0:    cmd_byte = urae_pkg::BYTE_SYNC;
            3'd1:    cmd_byte = is_read_reg ? urae_pkg::BYTE_OP_READ : urae_pkg::BYTE_OP_WRITE;
            3'd2:    cmd_byte = sreg_reg;
            3'd3:    cmd_byte = is_read_reg ? 8'(slen_reg) : urae_pkg::BYTE_WR_LEN;
            3'd4:    cmd_byte = sdata_reg;
            default: cmd_byte = urae_pkg::BYTE_SYNC;
        endcase
    end

    // output register
    assign out_load = cmd.emit_cmd_byte || cmd.emit_status || cmd.emit_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_cmd_byte) begin
            out_kind_reg   <= urae_pkg::KIND_TX;
            out_value_reg  <= cmd_byte;
            out_status_reg <= urae_pkg::ST_OK;
            out_last_reg   <= 1'b0;
        end else if (cmd.emit_status) begin
            out_kind_reg   <= urae_pkg::KIND_STATUS;
            out_value_reg  <= 8'd0;
            out_status_reg <= cmd.status_code;
            out_last_reg   <= 1'b1;
        end else if (cmd.emit_data) begin
            out_kind_reg   <= urae_pkg::KIND_DATA;
            out_value_reg  <= mem_q_reg;
            out_status_reg <= urae_pkg::ST_OK;
            out_last_reg   <= (rd_ptr_reg == slen_reg);
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

    // status toward the controller
    always_comb begin
        sts.is_read       = is_read_reg;
        sts.out_free      = !out_valid_reg || m_tready;
        sts.bad_len       = (read_len == 8'd0) || ({1'b0, read_len} > 9'(MAX_READ_LEN));
        sts.hdr_ok        = is_read_reg
                            ? (hdr_reg == urae_pkg::BYTE_RD_HDR && rx_byte == 8'(slen_reg))
                            : (hdr_reg == urae_pkg::BYTE_WR_ACK0
                               && rx_byte == urae_pkg::BYTE_WR_ACK1);
        sts.attempts_done = attempt_reg >= max_att_reg;
        sts.timeout_hit   = tick_next >= timeout_reg;
        sts.backoff_hit   = tick_next >= backoff_reg;
        sts.backoff_zero  = backoff_reg == 8'd0;
        sts.payload_done  = bytes_inc >= CW'(slen_reg);
        sts.rd_last       = rd_ptr_reg == slen_reg;
    end

    // payload bytes stay inside the requested length
    a_pay_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pay_write |-> (bytes_reg < slen_reg))
        else $error("payload write past requested length");

    // readout never runs past the stored payload
    a_rd_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |-> (rd_ptr_reg < slen_reg))
        else $error("payload read past stored length");

    // the output register is only loaded when it can take a new item
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("output overwritten while stalled");

endmodule

FILE: src/urae_ctrl.sv
module urae_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [1:0]     func,
    output urae_pkg::cmd_t cmd,
    input  urae_pkg::sts_t sts
);

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SEND    = 3'd1;
    localparam logic [2:0] S_STATUS  = 3'd2;
    localparam logic [2:0] S_DUMP_RD = 3'd3;
    localparam logic [2:0] S_DUMP_WR = 3'd4;

    // protocol phases
    localparam logic [2:0] P_IDLE    = 3'd0;
    localparam logic [2:0] P_HDR0    = 3'd1;
    localparam logic [2:0] P_HDR1    = 3'd2;
    localparam logic [2:0] P_PAYLOAD = 3'd3;
    localparam logic [2:0] P_BACKOFF = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [2:0] idx_reg, idx_next;
    logic [1:0] code_reg, code_next;
    logic [2:0] last_idx;

    assign s_tready = (state_reg == S_IDLE);
    assign last_idx = sts.is_read ? urae_pkg::RD_LAST_IDX : urae_pkg::WR_LAST_IDX;

    // next state and datapath commands
    always_comb begin
        logic do_send;
        logic do_fail;
        logic fail_bo;

        do_send    = 1'b0;
        do_fail    = 1'b0;
        fail_bo    = 1'b0;
        state_next = state_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.byte_idx    = idx_reg;
        cmd.status_code = code_reg;
        cmd.load_rd     = (func == urae_pkg::FUNC_READ);

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (func)
                        urae_pkg::FUNC_WRITE, urae_pkg::FUNC_READ: begin
                            if (phase_reg != P_IDLE) begin
                                code_next  = urae_pkg::ST_BUSY;
                                state_next = S_STATUS;
                            end else if (func == urae_pkg::FUNC_READ && sts.bad_len) begin
                                code_next  = urae_pkg::ST_BADLEN;
                                state_next = S_STATUS;
                            end else begin
                                cmd.load_req = 1'b1;
                                do_send      = 1'b1;
                            end
                        end
                        urae_pkg::FUNC_RX: begin
                            case (phase_reg)
                                P_HDR0: begin
                                    cmd.save_hdr = 1'b1;
                                    phase_next   = P_HDR1;
                                end
                                P_HDR1: begin
                                    if (sts.hdr_ok && sts.is_read) begin
                                        cmd.pay_start = 1'b1;
                                        phase_next    = P_PAYLOAD;
                                    end else if (sts.hdr_ok) begin
                                        phase_next = P_IDLE;
                                        code_next  = urae_pkg::ST_OK;
                                        state_next = S_STATUS;
                                    end else begin
                                        do_fail = 1'b1;
                                        fail_bo = 1'b1;
                                    end
                                end
                                P_PAYLOAD: begin
                                    cmd.pay_write = 1'b1;
                                    if (sts.payload_done) begin
                                        phase_next   = P_IDLE;
                                        cmd.rd_start = 1'b1;
                                        state_next   = S_DUMP_RD;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        urae_pkg::FUNC_TICK: begin
                            if (phase_reg != P_IDLE) begin
                                cmd.tick_inc = 1'b1;
                                if (phase_reg == P_BACKOFF) begin
                                    do_send = sts.backoff_hit;
                                end else if (sts.timeout_hit) begin
                                    do_fail = 1'b1;
                                    fail_bo = !sts.is_read;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SEND: begin
                if (sts.out_free) begin
                    cmd.emit_cmd_byte = 1'b1;
                    if (idx_reg == last_idx) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            S_STATUS: begin
                if (sts.out_free) begin
                    cmd.emit_status = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_DUMP_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_DUMP_WR;
            end
            S_DUMP_WR: begin
                if (sts.out_free) begin
                    cmd.emit_data = 1'b1;
                    state_next    = sts.rd_last ? S_IDLE : S_DUMP_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // failed attempt: give up, back off, or resend at once
        if (do_fail) begin
            if (sts.attempts_done) begin
                phase_next = P_IDLE;
                code_next  = urae_pkg::ST_FAILED;
                state_next = S_STATUS;
            end else if (fail_bo && !sts.backoff_zero) begin
                phase_next   = P_BACKOFF;
                cmd.tick_clr = 1'b1;
            end else begin
                do_send = 1'b1;
            end
        end

        // start a command frame
        if (do_send) begin
            cmd.begin_cmd = 1'b1;
            phase_next    = P_HDR0;
            idx_next      = 3'd0;
            state_next    = S_SEND;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= P_IDLE;
            idx_reg   <= '0;
            code_reg  <= urae_pkg::ST_OK;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            code_reg  <= code_next;
        end
    end

    // a command frame is always followed by a header wait
    a_send_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEND) |-> (phase_reg == P_HDR0))
        else $error("command frame outside header wait");

    // at most one output source per cycle
    a_emit_one: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.emit_cmd_byte, cmd.emit_status, cmd.emit_data}))
        else $error("conflicting output loads");

    // readout only happens once the run has ended
    a_dump_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DUMP_RD || state_reg == S_DUMP_WR) |-> (phase_reg == P_IDLE))
        else $error("payload readout during an active run");

endmodule

FILE: src/uart_register_access_engine.sv
// channel   direction  handshake            payload
// s_        in         s_tvalid / s_tready  tdata: reg_addr, read_len, write_data, rx_byte;
//                                            tuser: func
// m_        out        m_tvalid / m_tready  tdata: value, status; tuser: kind; tlast: last
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Items are taken while idle; items that cause no result follow each other every cycle.
// A command frame transmits 4 (read) or 5 (write) bytes; a status item is a single result.
// Each read data byte is read from the registered payload memory, then loaded out.
// Reset (aresetn low, synchronous) clears control state; the payload memory is not cleared.
// m_tready low holds the output register and pauses the sequencer; the last result may
// wait there while the next item is accepted.
module uart_register_access_engine #(
    parameter int MAX_READ_LEN = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // reg_addr, read_len, write_data, rx_byte
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // value, status, zero fill
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    urae_pkg::cmd_t cmd;
    urae_pkg::sts_t sts;
    logic [7:0]     out_value;
    logic [1:0]     out_status;

    assign cfg_ready = 1'b1;

    // protocol sequencer
    urae_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (s_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

    // counters, request fields, payload store and output register
    urae_dp #(
        .MAX_READ_LEN (MAX_READ_LEN)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .reg_addr   (s_tdata[7:0]),
        .read_len   (s_tdata[15:8]),
        .write_data (s_tdata[23:16]),
        .rx_byte    (s_tdata[31:24]),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_kind   (m_tuser),
        .out_value  (out_value),
        .out_status (out_status),
        .out_last   (m_tlast)
    );

    assign m_tdata = {6'd0, out_status, out_value};

endmodule
